### src/smsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sparse matrix scatter-accumulate block.
// No dependencies.
package smsa_pkg;

  localparam int unsigned RowTotalW = 11;

  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_ACC    = 3'd2;
  localparam logic [2:0] MODE_ZERO   = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;
  localparam logic [2:0] MODE_ACK    = 3'd5;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_IGNORED = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_ORDER   = 2'd3;

  localparam logic [1:0] CHG_STRUCT = 2'd0;
  localparam logic [1:0] CHG_COEFF  = 2'd1;
  localparam logic [1:0] CHG_SAME   = 2'd2;

  typedef struct packed {
    logic capture;
    logic decode;
    logic rs_hi;
    logic rs_wait;
    logic scan_rd;
    logic scan_cmp;
    logic st_use;
    logic acc_wr;
    logic sweep;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic search;
    logic zero;
    logic scan_end;
    logic col_hit;
    logic is_acc;
    logic sweep_end;
  } sts_t;

endpackage

### src/smsa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module smsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/smsa_datapath.sv
`timescale 1ns / 1ps
// Datapath: request registers, pattern and value memories, multiply and saturating add.
// Depends on smsa_pkg and smsa_ram.
module smsa_datapath #(
  parameter int unsigned MAX_EQUATIONS = 1024,
  parameter int unsigned MAX_ENTRIES   = 16384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smsa_pkg::cmd_t                cmd_i,
  output smsa_pkg::sts_t                sts_o,
  input  logic [2:0]                    mode_i,
  input  logic [9:0]                    row_i,
  input  logic [9:0]                    col_i,
  input  logic signed [31:0]            value_i,
  input  logic signed [31:0]            scale_i,
  input  logic                          target_i,
  output logic [1:0]                    status_o,
  output logic signed [63:0]            read_value_o,
  output logic                          found_o,
  output logic [1:0]                    matrix_state_o,
  output logic [smsa_pkg::RowTotalW-1:0] equation_count_o
);

  localparam int unsigned EW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned RSD  = MAX_EQUATIONS + 1;
  localparam int unsigned RSAW = $clog2(RSD);
  localparam int unsigned RTW  = smsa_pkg::RowTotalW;

  logic [2:0]         mode_q;
  logic [9:0]         row_q, col_q;
  logic signed [31:0] value_q, scale_q;
  logic               target_q;
  logic signed [63:0] product_q, sum_q;
  logic [EW-1:0]      et_q, et_d, k_q, k_d, hi_q, hi_d;
  logic [RTW-1:0]     rt_q, rt_d;
  logic [1:0]         chg_q, chg_d;
  logic [1:0]         res_status_q, res_status_d;
  logic               res_found_q, res_found_d;
  logic signed [63:0] res_rd_q, res_rd_d;
  logic [1:0]         out_status_q;
  logic               out_found_q;
  logic signed [63:0] out_rd_q;
  logic [1:0]         out_chg_q;
  logic [RTW-1:0]     out_rt_q;

  logic [EW-1:0]      rs_rdata;
  logic [9:0]         col_rdata;
  logic [63:0]        stf_rdata, mas_rdata;
  logic signed [63:0] st_rdata;
  logic [64:0]        sum_wide;
  logic signed [63:0] sum_sat;

  logic           range_bad, app_range_bad, app_extend, app_new, app_full, app_ok;
  logic [RTW-1:0] rt_inc, rt_app;
  logic [EW-1:0]  et_inc;
  logic           sweep_w, st_we_sel, stf_we, mas_we;
  logic [AW-1:0]  st_waddr;
  logic [63:0]    st_wdata;
  logic [RSAW-1:0] rs_raddr;

  assign range_bad = ({1'b0, row_q} >= rt_q) || ({1'b0, col_q} >= rt_q);
  assign app_range_bad = (32'(row_q) >= 32'(MAX_EQUATIONS)) ||
                         (32'(col_q) >= 32'(MAX_EQUATIONS));
  assign app_extend = (rt_q != '0) && ({1'b0, row_q} == rt_q - RTW'(1));
  assign app_new    = ({1'b0, row_q} == rt_q);
  assign app_full   = (et_q >= EW'(MAX_ENTRIES));
  assign app_ok     = cmd_i.decode && (mode_q == smsa_pkg::MODE_APPEND) && !app_range_bad &&
                      (app_extend || app_new) && !app_full;
  assign rt_inc = rt_q + RTW'(1);
  assign rt_app = app_new ? rt_inc : rt_q;
  assign et_inc = et_q + EW'(1);

  assign st_rdata = target_q ? $signed(mas_rdata) : $signed(stf_rdata);
  assign sum_wide = {product_q[63], product_q} + {st_rdata[63], st_rdata};
  always_comb begin
    if (sum_wide[64] != sum_wide[63]) begin
      sum_sat = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_sat = $signed(sum_wide[63:0]);
    end
  end

  assign sweep_w   = cmd_i.sweep && (k_q < et_q);
  assign st_we_sel = cmd_i.acc_wr || sweep_w;
  assign stf_we    = app_ok || (st_we_sel && !target_q);
  assign mas_we    = app_ok || (st_we_sel && target_q);
  assign st_waddr  = app_ok ? AW'(et_q) : AW'(k_q);
  assign st_wdata  = cmd_i.acc_wr ? sum_q : 64'd0;
  assign rs_raddr  = cmd_i.rs_hi ? RSAW'({1'b0, row_q} + 11'd1) : RSAW'(row_q);

  smsa_ram #(.WIDTH(EW), .DEPTH(RSD)) u_row_start (
    .clk_i, .we_i(app_ok), .waddr_i(RSAW'(rt_app)), .wdata_i(et_inc),
    .raddr_i(rs_raddr), .rdata_o(rs_rdata)
  );

  smsa_ram #(.WIDTH(10), .DEPTH(MAX_ENTRIES)) u_col (
    .clk_i, .we_i(app_ok), .waddr_i(AW'(et_q)), .wdata_i(col_q),
    .raddr_i(AW'(k_q)), .rdata_o(col_rdata)
  );

  smsa_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_stiff (
    .clk_i, .we_i(stf_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(AW'(k_q)), .rdata_o(stf_rdata)
  );

  smsa_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_mass (
    .clk_i, .we_i(mas_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(AW'(k_q)), .rdata_o(mas_rdata)
  );

  always_comb begin
    et_d = et_q;
    rt_d = rt_q;
    chg_d = chg_q;
    k_d = k_q;
    hi_d = hi_q;
    res_status_d = res_status_q;
    res_found_d = res_found_q;
    res_rd_d = res_rd_q;
    if (cmd_i.decode) begin
      res_status_d = smsa_pkg::STATUS_DONE;
      res_found_d = 1'b0;
      res_rd_d = '0;
      k_d = '0;
      case (mode_q)
        smsa_pkg::MODE_CLEAR: begin
          et_d = '0;
          rt_d = '0;
          chg_d = smsa_pkg::CHG_STRUCT;
        end
        smsa_pkg::MODE_APPEND: begin
          if (app_range_bad) begin
            res_status_d = smsa_pkg::STATUS_IGNORED;
          end else if (!(app_extend || app_new)) begin
            res_status_d = smsa_pkg::STATUS_ORDER;
          end else if (app_full) begin
            res_status_d = smsa_pkg::STATUS_FULL;
          end else begin
            et_d = et_inc;
            rt_d = rt_app;
            chg_d = smsa_pkg::CHG_STRUCT;
          end
        end
        smsa_pkg::MODE_ACC: begin
          if (scale_q != '0 && range_bad) begin
            res_status_d = smsa_pkg::STATUS_IGNORED;
          end
        end
        smsa_pkg::MODE_ZERO: begin
          if (chg_q == smsa_pkg::CHG_STRUCT) begin
            chg_d = smsa_pkg::CHG_COEFF;
          end
        end
        smsa_pkg::MODE_READ: begin
          if (range_bad) begin
            res_status_d = smsa_pkg::STATUS_IGNORED;
          end
        end
        smsa_pkg::MODE_ACK: begin
          chg_d = smsa_pkg::CHG_SAME;
        end
        default: begin
          res_status_d = smsa_pkg::STATUS_IGNORED;
        end
      endcase
    end
    if (cmd_i.rs_hi) begin
      k_d = (row_q == '0) ? '0 : rs_rdata;
    end
    if (cmd_i.rs_wait) begin
      hi_d = rs_rdata;
    end
    if (cmd_i.scan_rd && (k_q >= hi_q)) begin
      res_status_d = smsa_pkg::STATUS_IGNORED;
    end
    if (cmd_i.scan_cmp && (col_rdata != col_q)) begin
      k_d = k_q + EW'(1);
    end
    if (cmd_i.st_use && (mode_q == smsa_pkg::MODE_READ)) begin
      res_found_d = 1'b1;
      res_rd_d = st_rdata;
    end
    if (cmd_i.acc_wr) begin
      res_found_d = 1'b1;
      if (chg_q != smsa_pkg::CHG_STRUCT) begin
        chg_d = smsa_pkg::CHG_COEFF;
      end
    end
    if (sweep_w) begin
      k_d = k_q + EW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      et_q <= '0;
      rt_q <= '0;
      chg_q <= smsa_pkg::CHG_STRUCT;
    end else begin
      et_q <= et_d;
      rt_q <= rt_d;
      chg_q <= chg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      row_q <= row_i;
      col_q <= col_i;
      value_q <= value_i;
      scale_q <= scale_i;
      target_q <= target_i;
    end
    if (cmd_i.decode) begin
      product_q <= value_q * scale_q;
    end
    if (cmd_i.st_use) begin
      sum_q <= sum_sat;
    end
    k_q <= k_d;
    hi_q <= hi_d;
    res_status_q <= res_status_d;
    res_found_q <= res_found_d;
    res_rd_q <= res_rd_d;
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_found_q <= res_found_q;
      out_rd_q <= res_rd_q;
      out_chg_q <= chg_q;
      out_rt_q <= rt_q;
    end
  end

  assign sts_o.search = ((mode_q == smsa_pkg::MODE_ACC && scale_q != '0) ||
                         mode_q == smsa_pkg::MODE_READ) && !range_bad;
  assign sts_o.zero      = (mode_q == smsa_pkg::MODE_ZERO);
  assign sts_o.scan_end  = (k_q >= hi_q);
  assign sts_o.col_hit   = (col_rdata == col_q);
  assign sts_o.is_acc    = (mode_q == smsa_pkg::MODE_ACC);
  assign sts_o.sweep_end = (k_q >= et_q);

  assign status_o         = out_status_q;
  assign read_value_o     = out_rd_q;
  assign found_o          = out_found_q;
  assign matrix_state_o   = out_chg_q;
  assign equation_count_o = out_rt_q;

endmodule

### src/smsa_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one request through decode, search, update and result hand-off.
// Depends on smsa_pkg.
module smsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  smsa_pkg::sts_t sts_i,
  output smsa_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DECODE   = 11'b00000000010,
    S_RS_LO    = 11'b00000000100,
    S_RS_HI    = 11'b00000001000,
    S_RS_WAIT  = 11'b00000010000,
    S_SCAN_RD  = 11'b00000100000,
    S_SCAN_CMP = 11'b00001000000,
    S_ST_WAIT  = 11'b00010000000,
    S_ACC_WR   = 11'b00100000000,
    S_SWEEP    = 11'b01000000000,
    S_PUSH     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.search) begin
          state_d = S_RS_LO;
        end else if (sts_i.zero) begin
          state_d = S_SWEEP;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_RS_LO: begin
        state_d = S_RS_HI;
      end
      S_RS_HI: begin
        cmd_o.rs_hi = 1'b1;
        state_d = S_RS_WAIT;
      end
      S_RS_WAIT: begin
        cmd_o.rs_wait = 1'b1;
        state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = sts_i.scan_end ? S_PUSH : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d = sts_i.col_hit ? S_ST_WAIT : S_SCAN_RD;
      end
      S_ST_WAIT: begin
        cmd_o.st_use = 1'b1;
        state_d = sts_i.is_acc ? S_ACC_WR : S_PUSH;
      end
      S_ACC_WR: begin
        cmd_o.acc_wr = 1'b1;
        state_d = S_PUSH;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_end) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/sparse_matrix_scatter_accumulate.sv
`timescale 1ns / 1ps
// Sparse matrix scatter-accumulate: row-compressed pattern with stiffness and mass stores.
// Top level; depends on smsa_pkg, smsa_ctrl and smsa_datapath.
//
// Usage: one request on the input channel (mode, row, col, value, scale,
// target) gives exactly one result on the output channel (status, read_value,
// found, matrix_state, equation_count). Both channels use valid/ready.
// One request is worked on at a time; a new one is taken as soon as the
// previous result sits in the output register, even while that result waits.
// Steps from accept to result valid, with the output register free:
//   clear, append, acknowledge, ignored or zero-scale requests: decode, then push
//   accumulate, read: decode, row-start lookup, then a read and a compare state
//     per pattern entry of the row examined up to the match (the column memory's
//     read port is registered), the store read, an accumulate write-back, push
//   zero store: decode, then one store entry cleared per cycle, then push
// The input is ready again in the cycle after the result is loaded.
// Reset empties the pattern and sets the change state to structure changed;
// the memories need no clearing pass. A stalled receiver holds the result
// and, once the next request is finished, holds that one back as well.
module sparse_matrix_scatter_accumulate #(
  parameter int unsigned MAX_EQUATIONS = 1024,
  parameter int unsigned MAX_ENTRIES   = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          mode_i,
  input  logic [9:0]          row_i,
  input  logic [9:0]          col_i,
  input  logic signed [31:0]  value_i,
  input  logic signed [31:0]  scale_i,
  input  logic                target_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [63:0]  read_value_o,
  output logic                found_o,
  output logic [1:0]          matrix_state_o,
  output logic [10:0]         equation_count_o
);

  smsa_pkg::cmd_t cmd;
  smsa_pkg::sts_t sts;

  smsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  smsa_datapath #(
    .MAX_EQUATIONS(MAX_EQUATIONS),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .mode_i, .row_i, .col_i, .value_i, .scale_i, .target_i,
    .status_o, .read_value_o, .found_o, .matrix_state_o, .equation_count_o
  );

endmodule

### src/smsa_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sparse matrix scatter-accumulate block, bound to the top level.
// Depends on sparse_matrix_scatter_accumulate.
module smsa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic signed [63:0] read_value_o,
  input logic               found_o,
  input logic [1:0]         matrix_state_o,
  input logic [10:0]        equation_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o) &&
      $stable(status_o))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in work");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == 2'd0)
    else $error("found entry reported with failing status");

  a_value_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_value_o != 64'd0 |-> found_o)
    else $error("nonzero read value without a found entry");

  a_state_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> matrix_state_o != 2'd3 && equation_count_o <= 11'd1024)
    else $error("matrix state or equation count out of range");

endmodule

bind sparse_matrix_scatter_accumulate smsa_checker u_smsa_checker (.*);
